FILE: design/dksc_pkg.sv
// Shared types, sizes and event codes of the debounced key speed command block.
package dksc_pkg;

  localparam int NUM_KEYS    = 5;
  localparam int SPEED_WIDTH = 16;
  // Working width for saturating speed arithmetic: room for the config value
  // and two spare bits above the larger of the two widths.
  localparam int SAT_W = ((SPEED_WIDTH > 16) ? SPEED_WIDTH : 16) + 2;

  localparam logic [2:0] EVT_NONE  = 3'd0;
  localparam logic [2:0] EVT_START = 3'd1;
  localparam logic [2:0] EVT_STOP  = 3'd2;
  localparam logic [2:0] EVT_UP    = 3'd3;
  localparam logic [2:0] EVT_DOWN  = 3'd4;
  localparam logic [2:0] EVT_NEG   = 3'd5;

  localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [1:0] REG_START_SPEED    = 2'd1;
  localparam logic [1:0] REG_SPEED_STEP     = 2'd2;

  localparam logic [7:0]         DEBOUNCE_RESET = 8'd10;
  localparam logic signed [15:0] START_RESET    = 16'sd1000;
  localparam logic [14:0]        STEP_RESET     = 15'd200;

  typedef struct packed {
    logic [NUM_KEYS-1:0] key_levels;
    logic                motor_running;
  } key_item_t;

  typedef struct packed {
    logic [2:0]         key_event;
    logic signed [15:0] speed_target;
    logic               speed_update;
    logic               start_request;
    logic               stop_request;
  } speed_result_t;

  typedef struct packed {
    logic [7:0]         debounce_ticks;
    logic signed [15:0] start_speed;
    logic [14:0]        speed_step;
  } cfg_regs_t;

endpackage

FILE: design/dksc_key_scan.sv
// Per-key debounce counters, press latches and lowest-index press pick.
module dksc_key_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          update,
  input  logic [dksc_pkg::NUM_KEYS-1:0] key_levels,
  input  logic [7:0]                    debounce_ticks,
  output logic [2:0]                    key_event
);
  import dksc_pkg::*;

  logic [7:0] hold_count [NUM_KEYS];
  logic [7:0] hold_count_next [NUM_KEYS];
  logic [NUM_KEYS-1:0] press_latched;
  logic [NUM_KEYS-1:0] press_latched_next;

  always_comb begin
    logic       found;
    logic [7:0] cnt;
    found = 1'b0;
    key_event = EVT_NONE;
    for (int i = 0; i < NUM_KEYS; i++) begin
      hold_count_next[i]    = hold_count[i];
      press_latched_next[i] = press_latched[i];
      cnt = hold_count[i];
      // keys after the reported one are left untouched this beat
      if (!found) begin
        if (key_levels[i]) begin
          if (cnt < debounce_ticks) begin
            cnt = cnt + 8'd1;
          end
          hold_count_next[i] = cnt;
          if (cnt >= debounce_ticks && !press_latched[i]) begin
            press_latched_next[i] = 1'b1;
            key_event = 3'(i + 1);
            found = 1'b1;
          end
        end else begin
          hold_count_next[i]    = 8'd0;
          press_latched_next[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        hold_count[i] <= 8'd0;
      end
      press_latched <= '0;
    end else if (update) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        hold_count[i] <= hold_count_next[i];
      end
      press_latched <= press_latched_next;
    end
  end

endmodule

FILE: design/dksc_speed_cmd.sv
// Speed target register with saturating set, step, and negate commands.
module dksc_speed_cmd (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   update,
  input  logic [2:0]             key_event,
  input  logic                   motor_running,
  input  dksc_pkg::cfg_regs_t    cfg,
  output dksc_pkg::speed_result_t result
);
  import dksc_pkg::*;

  localparam logic signed [SAT_W-1:0] SPEED_MAX =
    SAT_W'((64'sd1 <<< (SPEED_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SPEED_MIN = -SPEED_MAX - SAT_W'(1);

  logic signed [SPEED_WIDTH-1:0] target_rpm;
  logic signed [SPEED_WIDTH-1:0] target_rpm_next;
  logic signed [SAT_W-1:0]       wide_target;
  logic signed [SAT_W-1:0]       wide_step;
  logic signed [SAT_W-1:0]       raw;
  logic                          upd;

  assign wide_target = SAT_W'(target_rpm);
  assign wide_step   = SAT_W'($signed({1'b0, cfg.speed_step}));

  always_comb begin
    upd = 1'b1;
    unique case (key_event)
      EVT_START: raw = SAT_W'(cfg.start_speed);
      EVT_UP:    raw = wide_target + wide_step;
      EVT_DOWN:  raw = wide_target - wide_step;
      EVT_NEG:   raw = -wide_target;
      default: begin
        raw = wide_target;
        upd = 1'b0;
      end
    endcase
    // clamp to the signed range of the target register
    if (raw > SPEED_MAX) begin
      target_rpm_next = SPEED_WIDTH'(SPEED_MAX);
    end else if (raw < SPEED_MIN) begin
      target_rpm_next = SPEED_WIDTH'(SPEED_MIN);
    end else begin
      target_rpm_next = SPEED_WIDTH'(raw);
    end
  end

  always_comb begin
    result.key_event     = key_event;
    result.speed_target  = 16'(target_rpm_next);
    result.speed_update  = upd;
    result.start_request = upd && !motor_running;
    result.stop_request  = (key_event == EVT_STOP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_rpm <= '0;
    end else if (update) begin
      target_rpm <= target_rpm_next;
    end
  end

endmodule

FILE: design/debounced_key_speed_command.sv
// Top level: input register, configuration registers, and result register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one tick: the levels
//   of the keys and the motor-running flag. Each accepted beat yields exactly
//   one result beat on the output channel (out_valid / out_stall / out_data):
//   the key pressed this tick (0 for none), the speed target after the tick,
//   and the update, start and stop request flags.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   debounce limit, start speed and speed step; cfg_ready is always high and
//   writes belong in idle periods. Unknown indexes are ignored.
// Path: a beat taken into the input register moves on to the result register,
//   with out_valid high, once the output stage can advance.
// Throughput: one beat per cycle while out_stall is low; the debounce state and
//   speed target update in the same cycle a beat moves into the result register.
// Reset: counters, latches and target clear to zero, registers take their
//   defaults (10 ticks, 1000 rpm, 200 rpm), both pipeline stages empty.
// Stall: a held result keeps its stage; the input register then holds too and
//   in_stall rises while it is full, so no beat is lost or repeated.
module debounced_key_speed_command (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  dksc_pkg::key_item_t     in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output dksc_pkg::speed_result_t out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data
);
  import dksc_pkg::*;

  cfg_regs_t     cfg;
  key_item_t     s1_item;
  logic          s1_valid;
  logic          advance;
  logic          accept;
  logic          update;
  logic [2:0]    key_event;
  speed_result_t result;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign update    = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.start_speed    <= START_RESET;
      cfg.speed_step     <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks <= cfg_data[7:0];
        REG_START_SPEED:    cfg.start_speed    <= $signed(cfg_data);
        REG_SPEED_STEP:     cfg.speed_step     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_data;
    end
  end

  dksc_key_scan u_key_scan (
    .clk            (clk),
    .rst            (rst),
    .update         (update),
    .key_levels     (s1_item.key_levels),
    .debounce_ticks (cfg.debounce_ticks),
    .key_event      (key_event)
  );

  dksc_speed_cmd u_speed_cmd (
    .clk           (clk),
    .rst           (rst),
    .update        (update),
    .key_event     (key_event),
    .motor_running (s1_item.motor_running),
    .cfg           (cfg),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // hold the result beat while the receiver stalls
  always_ff @(posedge clk) begin
    if (update) begin
      out_data <= result;
    end
  end

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the debounced key speed command block.
module testbench;
  import dksc_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  key_item_t     in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  speed_result_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = REG_DEBOUNCE_TICKS;
  logic [15:0]   cfg_data = '0;

  debounced_key_speed_command dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state and register copies
  logic [7:0]         hold_ticks [NUM_KEYS];
  logic               latched [NUM_KEYS];
  logic signed [15:0] cur_target;
  logic [7:0]         limit_ticks;
  logic signed [15:0] start_rpm;
  logic [14:0]        step_rpm;

  speed_result_t speed_results_due[$];
  int            error_count = 0;
  int            quiet_cycles = 0;
  bit            gaps_on = 1'b0;

  function automatic logic signed [15:0] clamp_rpm(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Advance the predictor by one tick and return the result it calls for.
  function automatic speed_result_t scan_keys(key_item_t item);
    speed_result_t r;
    logic [2:0]    ev;
    ev = EVT_NONE;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (ev == EVT_NONE) begin
        if (item.key_levels[k]) begin
          if (hold_ticks[k] < limit_ticks) hold_ticks[k] = hold_ticks[k] + 8'd1;
          if (hold_ticks[k] >= limit_ticks && !latched[k]) begin
            latched[k] = 1'b1;
            ev = 3'(k + 1);
          end
        end else begin
          hold_ticks[k] = '0;
          latched[k] = 1'b0;
        end
      end
    end
    r = '0;
    r.key_event = ev;
    case (ev)
      EVT_START: cur_target = start_rpm;
      EVT_UP:    cur_target = clamp_rpm(int'(cur_target) + int'(step_rpm));
      EVT_DOWN:  cur_target = clamp_rpm(int'(cur_target) - int'(step_rpm));
      EVT_NEG:   cur_target = clamp_rpm(-int'(cur_target));
      default: ;
    endcase
    r.speed_target  = cur_target;
    r.speed_update  = (ev == EVT_START || ev == EVT_UP || ev == EVT_DOWN || ev == EVT_NEG);
    r.start_request = r.speed_update && !item.motor_running;
    r.stop_request  = (ev == EVT_STOP);
    return r;
  endfunction

  function automatic key_item_t key_tick(logic [NUM_KEYS-1:0] keys, logic run);
    key_item_t t;
    t.key_levels = keys;
    t.motor_running = run;
    return t;
  endfunction

  task automatic send_tick(input key_item_t item);
    while (gaps_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    speed_results_due.push_back(scan_keys(item));
  endtask

  // Drop valid and wait for every result, then let the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (speed_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data,
                           input bit last = 1'b1);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      REG_DEBOUNCE_TICKS: limit_ticks = data[7:0];
      REG_START_SPEED:    start_rpm = data;
      REG_SPEED_STEP:     step_rpm = data[14:0];
      default: ;
    endcase
  endtask

  task automatic hold_keys(input logic [NUM_KEYS-1:0] keys, input int n);
    repeat (n) send_tick(key_tick(keys, 1'($urandom)));
  endtask

  // Default registers: a press after ten high ticks loads 1000 rpm.
  task automatic test_default_regs();
    gaps_on = 1'b0;
    repeat (11) send_tick(key_tick(5'b00001, 1'b0));
    send_tick(key_tick(5'b00000, 1'b1));
  endtask

  // Every key with a one-tick limit, then all keys held to show the priority scan.
  task automatic test_each_key();
    settle();
    write_reg(REG_DEBOUNCE_TICKS, 16'd1);
    send_tick(key_tick(5'b00000, 1'b0));
    send_tick(key_tick(5'b00100, 1'b1));
    send_tick(key_tick(5'b01000, 1'b0));
    send_tick(key_tick(5'b10000, 1'b0));
    send_tick(key_tick(5'b00010, 1'b1));
    send_tick(key_tick(5'b00000, 1'b0));
    repeat (6) send_tick(key_tick(5'b11111, 1'($urandom)));
    send_tick(key_tick(5'b10101, 1'b0));
    send_tick(key_tick(5'b00000, 1'b1));
  endtask

  // A zero limit fires on the first high tick and never counts.
  task automatic test_limit_zero();
    settle();
    write_reg(REG_DEBOUNCE_TICKS, 16'ha500);
    send_tick(key_tick(5'b00001, 1'b1));
    send_tick(key_tick(5'b00001, 1'b1));
    send_tick(key_tick(5'b00011, 1'b0));
    send_tick(key_tick(5'b00000, 1'b0));
    send_tick(key_tick(5'b00001, 1'b0));
  endtask

  // Hold keys partway, then lower the limit under the longer-held key's count.
  task automatic test_limit_lowered();
    settle();
    write_reg(REG_DEBOUNCE_TICKS, 16'd8);
    hold_keys(5'b00100, 3);
    hold_keys(5'b01100, 2);
    settle();
    write_reg(REG_DEBOUNCE_TICKS, 16'd3);
    hold_keys(5'b01100, 3);
    send_tick(key_tick(5'b00000, 1'b0));
  endtask

  // Drive the target into both rails; unknown index must not disturb anything.
  task automatic test_saturation();
    settle();
    write_reg(REG_DEBOUNCE_TICKS, 16'd1, 1'b0);
    write_reg(REG_START_SPEED, 16'h7fff, 1'b0);
    write_reg(2'd3, 16'hffff, 1'b0);
    write_reg(REG_SPEED_STEP, 16'hffff);
    send_tick(key_tick(5'b00001, 1'b0));
    send_tick(key_tick(5'b00100, 1'b0));
    send_tick(key_tick(5'b10000, 1'b1));
    send_tick(key_tick(5'b01000, 1'b0));
    send_tick(key_tick(5'b10000, 1'b0));
    settle();
    write_reg(REG_START_SPEED, 16'h8000);
    send_tick(key_tick(5'b00001, 1'b1));
    send_tick(key_tick(5'b01000, 1'b0));
    send_tick(key_tick(5'b10000, 1'b0));
    send_tick(key_tick(5'b00100, 1'b0));
  endtask

  // Largest limit: the count saturates at 255 and the press lands when it reaches 255.
  task automatic test_longest_limit();
    settle();
    write_reg(REG_DEBOUNCE_TICKS, 16'h00ff, 1'b0);
    write_reg(REG_SPEED_STEP, 16'd1);
    gaps_on = 1'b1;
    hold_keys(5'b00100, 258);
    send_tick(key_tick(5'b00000, 1'b0));
  endtask

  task automatic randomize_regs();
    int          pick;
    logic [7:0]  lim;
    logic [15:0] spd;
    logic [15:0] stp;
    pick = $urandom_range(99);
    if (pick < 10) lim = 8'd0;
    else if (pick < 70) lim = 8'($urandom_range(1, 4));
    else lim = 8'($urandom_range(5, 12));
    pick = $urandom_range(99);
    if (pick < 15) spd = 16'h7fff;
    else if (pick < 30) spd = 16'h8000;
    else spd = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) stp = 16'($urandom) | 16'h7fff;
    else if (pick < 70) stp = {1'($urandom), 15'($urandom_range(0, 2000))};
    else stp = 16'($urandom);
    settle();
    if ($urandom_range(99) < 20) write_reg(2'd3, 16'($urandom), 1'b0);
    write_reg(REG_DEBOUNCE_TICKS, {8'($urandom), lim}, 1'b0);
    write_reg(REG_START_SPEED, spd, 1'b0);
    write_reg(REG_SPEED_STEP, stp);
  endtask

  // Mostly held presses around the limit, with noise ticks mixed in.
  task automatic test_random_presses(input int n_items, input bit gaps);
    int                  sent;
    int                  hold;
    logic [NUM_KEYS-1:0] mask;
    randomize_regs();
    gaps_on = gaps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_tick(key_tick(NUM_KEYS'($urandom), 1'($urandom)));
        sent++;
      end else begin
        if ($urandom_range(99) < 75) mask = NUM_KEYS'(1) << $urandom_range(NUM_KEYS - 1);
        else mask = NUM_KEYS'($urandom_range(1, 31));
        hold = int'(limit_ticks) + $urandom_range(3) - 1;
        if (hold < 1) hold = 1;
        hold_keys(mask, hold);
        sent += hold;
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(1)) send_tick(key_tick('0, 1'($urandom)));
          else send_tick(key_tick(NUM_KEYS'($urandom) & ~mask, 1'($urandom)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      hold_ticks[k] = '0;
      latched[k] = 1'b0;
    end
    cur_target = '0;
    limit_ticks = DEBOUNCE_RESET;
    start_rpm = START_RESET;
    step_rpm = STEP_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_default_regs();
    test_each_key();
    test_limit_zero();
    test_limit_lowered();
    test_saturation();
    test_longest_limit();
    for (int p = 0; p < 8; p++) test_random_presses(180, p != 3);
    settle();
    if (error_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !rst && gaps_on && ($urandom_range(99) < 10);
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    speed_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (speed_results_due.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        want = speed_results_due.pop_front();
        check_field("key_event", int'(want.key_event), int'(out_data.key_event));
        check_field("speed_target", int'($signed(want.speed_target)),
                    int'($signed(out_data.speed_target)));
        check_field("speed_update", int'(want.speed_update), int'(out_data.speed_update));
        check_field("start_request", int'(want.start_request),
                    int'(out_data.start_request));
        check_field("stop_request", int'(want.stop_request), int'(out_data.stop_request));
      end
    end
  end

  // Stop a hung run: count cycles with no beat on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

endmodule
